>>> rtl/core/emf_pkg.sv
// ----------------------------------------------------------------------------
// emf_pkg
// shared types and constants for the evidential mass fusion block
// ----------------------------------------------------------------------------
package emf_pkg;

    localparam int MassW = 16;
    localparam int SlotMax = 8;
    localparam int NumSetsDefault = 8;
    localparam logic [MassW-1:0] QOne = 16'h8000;

    typedef enum logic [1:0] {
        MODE_DEMPSTER    = 2'd0,
        MODE_CONJUNCTIVE = 2'd1,
        MODE_DISJUNCTIVE = 2'd2,
        MODE_HOLD        = 2'd3
    } mode_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMBINE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mac_start;
        logic mac_step;
        logic finish;
        logic div_start;
        logic div_step;
    } cmd_t;

    typedef struct packed {
        logic mac_done;
        logic div_done;
        logic need_div;
    } status_t;

endpackage

>>> rtl/core/emf_ctrl.sv
// ----------------------------------------------------------------------------
// emf_ctrl
// sequencer: load, or a product pass over rows, then rounding or serial divide
// ----------------------------------------------------------------------------
module emf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic             last_agent,
    output logic             out_valid,
    input  logic             out_ready,
    output emf_pkg::cmd_t    cmd,
    input  emf_pkg::status_t status
);
    emf_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emf_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            emf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = last_agent;
                    if (opcode == emf_pkg::OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = last_agent ? emf_pkg::ST_OUT : emf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.mac_start = 1'b1;
                        state_next    = emf_pkg::ST_MAC;
                    end
                end
            end
            emf_pkg::ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.mac_done)
                    state_next = emf_pkg::ST_ROUND;
            end
            emf_pkg::ST_ROUND:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = emf_pkg::ST_DIV;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = last_reg ? emf_pkg::ST_OUT : emf_pkg::ST_IDLE;
                end
            end
            emf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = last_reg ? emf_pkg::ST_OUT : emf_pkg::ST_IDLE;
            end
            emf_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = emf_pkg::ST_IDLE;
            end
            default: state_next = emf_pkg::ST_IDLE;
        endcase
    end
endmodule

>>> rtl/core/emf_dp.sv
// ----------------------------------------------------------------------------
// emf_dp
// accumulator, eight product lanes and a restoring divider for normalization
// ----------------------------------------------------------------------------
module emf_dp #(
    parameter int NUM_SETS = emf_pkg::NumSetsDefault
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      fusion_mode,
    input  logic [emf_pkg::SlotMax-1:0][15:0] mass_in,
    input  emf_pkg::cmd_t                   cmd,
    output emf_pkg::status_t                status,
    output logic [emf_pkg::SlotMax-1:0][15:0] fused,
    output logic                            fault
);
    localparam int SumW = 36;
    localparam int DivN = SumW + 15;

    logic [emf_pkg::SlotMax-1:0][15:0]     acc_reg;
    logic [emf_pkg::SlotMax-1:0][15:0]     agent_reg;
    logic [emf_pkg::SlotMax-1:0][SumW-1:0] sum_reg;
    logic [emf_pkg::SlotMax-1:0][SumW-1:0] sum_next;
    logic [1:0]  mode_reg;
    logic [2:0]  row_reg;
    logic        fault_reg;
    logic [2:0]  slot_reg;
    logic [2:0]  slot_nx;
    logic [5:0]  bit_reg;
    logic [DivN-1:0] num_reg;
    logic [30:0] rem_reg;
    logic [SumW-1:0] den_full;
    logic [30:0] den_w;
    logic [15:0] lane_a;
    logic [31:0] rem_shift;
    logic [32:0] trial;
    logic [DivN-1:0] quot;
    logic [15:0] quot_sat;
    logic [2:0]  mac_idx;
    logic [31:0] mac_prod;

    function automatic logic [15:0] sat_round(input logic [SumW-1:0] s);
        logic [SumW-1:0] r;
        r = (s + SumW'(16384)) >> 15;
        return (r > SumW'(emf_pkg::QOne)) ? emf_pkg::QOne : r[15:0];
    endfunction

    assign lane_a = acc_reg[row_reg];
    assign den_full = SumW'(1 << 30) - sum_reg[0];
    assign den_w = den_full[30:0];
    assign slot_nx = slot_reg + 3'd1;
    assign rem_shift = {rem_reg, num_reg[DivN-1]};
    assign trial = {1'b0, rem_shift} - {2'b00, den_w};
    assign quot = {num_reg[DivN-2:0], ~trial[32]};
    assign quot_sat = (quot > DivN'(emf_pkg::QOne)) ? emf_pkg::QOne : quot[15:0];
    assign status.mac_done = (row_reg == 3'(NUM_SETS - 1));
    assign status.need_div = (mode_reg == emf_pkg::MODE_DEMPSTER)
                             && (sum_reg[0] < SumW'(1 << 30));
    assign status.div_done = (bit_reg == 6'(DivN - 1)) && (slot_reg == 3'(NUM_SETS - 1));
    assign fused = acc_reg;
    assign fault = fault_reg;

    // one accumulator row against all agent lanes
    always_comb
    begin
        sum_next = sum_reg;
        mac_idx  = '0;
        mac_prod = '0;
        for (int c = 0; c < emf_pkg::SlotMax; c++)
        begin
            mac_idx = (mode_reg == emf_pkg::MODE_DISJUNCTIVE) ? (row_reg | 3'(c))
                                                              : (row_reg & 3'(c));
            mac_prod = lane_a * agent_reg[c];
            if (c < NUM_SETS && int'(mac_idx) < NUM_SETS
                && (mode_reg != emf_pkg::MODE_HOLD))
                sum_next[mac_idx] = sum_next[mac_idx] + SumW'(mac_prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = 0; i < emf_pkg::SlotMax; i++)
                    acc_reg[i] <= (i < NUM_SETS) ? ((mass_in[i] > emf_pkg::QOne)
                                  ? emf_pkg::QOne : mass_in[i]) : 16'd0;
                fault_reg <= 1'b0;
            end
            if (cmd.mac_start && fusion_mode == emf_pkg::MODE_DEMPSTER)
                acc_reg[0] <= '0;
            if (cmd.finish && mode_reg != emf_pkg::MODE_HOLD)
            begin
                if (mode_reg == emf_pkg::MODE_DEMPSTER)
                begin
                    for (int i = 1; i < emf_pkg::SlotMax; i++)
                        acc_reg[i] <= 16'd0;
                    acc_reg[0] <= sat_round(sum_reg[0]);
                    fault_reg  <= 1'b1;
                end
                else
                    for (int i = 0; i < emf_pkg::SlotMax; i++)
                        acc_reg[i] <= (i < NUM_SETS) ? sat_round(sum_reg[i]) : 16'd0;
            end
            if (cmd.div_start)
                acc_reg[0] <= sat_round(sum_reg[0]);
            if (cmd.div_step && bit_reg == 6'(DivN - 1))
                acc_reg[slot_reg] <= quot_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_start)
        begin
            mode_reg <= fusion_mode;
            row_reg  <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < emf_pkg::SlotMax; i++)
                agent_reg[i] <= (i < NUM_SETS) ? ((mass_in[i] > emf_pkg::QOne)
                                ? emf_pkg::QOne : mass_in[i]) : 16'd0;
        end
        else if (cmd.mac_step)
        begin
            sum_reg <= sum_next;
            row_reg <= row_reg + 3'd1;
        end
        if (cmd.div_start)
        begin
            slot_reg <= 3'd1;
            bit_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= {sum_reg[1], 15'd0} + DivN'(den_w >> 1);
        end
        else if (cmd.div_step)
        begin
            if (bit_reg == 6'(DivN - 1))
            begin
                bit_reg  <= '0;
                slot_reg <= slot_nx;
                rem_reg  <= '0;
                num_reg  <= {sum_reg[slot_nx], 15'd0} + DivN'(den_w >> 1);
            end
            else
            begin
                bit_reg <= bit_reg + 6'd1;
                rem_reg <= trial[32] ? rem_shift[30:0] : trial[30:0];
                num_reg <= quot;
            end
        end
    end
endmodule

>>> rtl/core/evidential_mass_fusion_top.sv
// ----------------------------------------------------------------------------
// evidential_mass_fusion_top
// fuses per-cell mass functions over an eight-subset frame
// ----------------------------------------------------------------------------
// channel   direction  handshake
// in        input      in_valid / in_ready
// out       output     out_valid / out_ready
// cfg       input      cfg_we
// load: an accept; combine: an accept, a product pass over the rows on eight
// product lanes, then rounding; dempster adds a serial divide per non-empty slot
// reset clears the accumulator and fault, mode resets to conjunctive
// a result waits in the output register until taken
module evidential_mass_fusion_top #(
    parameter int NUM_SETS = emf_pkg::NumSetsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] mass_0, mass_1, mass_2, mass_3,
    input  logic [15:0] mass_4, mass_5, mass_6, mass_7,
    input  logic        last_agent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] fused_0, fused_1, fused_2, fused_3,
    output logic [15:0] fused_4, fused_5, fused_6, fused_7,
    output logic        total_conflict_fault
);
    logic [1:0] mode_reg;
    emf_pkg::cmd_t cmd;
    emf_pkg::status_t status;
    logic [emf_pkg::SlotMax-1:0][15:0] fused;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= emf_pkg::MODE_CONJUNCTIVE;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    emf_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .opcode, .last_agent,
        .out_valid, .out_ready, .cmd, .status
    );

    emf_dp #(.NUM_SETS(NUM_SETS)) u_dp (
        .clk, .rst_n, .fusion_mode(mode_reg),
        .mass_in({mass_7, mass_6, mass_5, mass_4, mass_3, mass_2, mass_1, mass_0}),
        .cmd, .status, .fused, .fault(total_conflict_fault)
    );

    assign {fused_7, fused_6, fused_5, fused_4, fused_3, fused_2, fused_1, fused_0} = fused;
endmodule

>>> rtl/core/emf_checker.sv
// ----------------------------------------------------------------------------
// emf_checker
// port-level checks for the fusion block
// ----------------------------------------------------------------------------
module emf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] fused_1
);
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fused_1 <= 16'h8000) else $error("mass above one");
endmodule

bind evidential_mass_fusion_top emf_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .fused_1
);

>>> tb/sv/tb_evidential_mass_fusion_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_evidential_mass_fusion_top
// self-checking bench for the evidential mass fusion block: a directed table
// of load and combine items, then random cells in randomly picked fusion modes, each
// result compared against an in-bench model of the fused accumulator
// ----------------------------------------------------------------------------
module tb_evidential_mass_fusion_top;

    typedef logic [15:0] mass_vec_t [8];

    typedef struct {
        logic      opcode;
        mass_vec_t mass;
        logic      last_agent;
    } agent_item_t;

    typedef struct {
        mass_vec_t fused;
        logic      fault;
    } fused_result_t;

    typedef struct {
        logic      opcode;
        mass_vec_t mass;
        logic      last_agent;
        logic      has_exp;
        mass_vec_t exp_fused;
        logic      exp_fault;
    } table_row_t;

    localparam int CycleLimit = 3000000;
    localparam int DrainCycles = 600;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [15:0] mass_0, mass_1, mass_2, mass_3, mass_4, mass_5, mass_6, mass_7;
    logic        last_agent;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] fused_0, fused_1, fused_2, fused_3, fused_4, fused_5, fused_6, fused_7;
    logic        total_conflict_fault;

    evidential_mass_fusion_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .mass_0(mass_0), .mass_1(mass_1), .mass_2(mass_2), .mass_3(mass_3),
        .mass_4(mass_4), .mass_5(mass_5), .mass_6(mass_6), .mass_7(mass_7),
        .last_agent(last_agent), .out_valid(out_valid), .out_ready(out_ready),
        .fused_0(fused_0), .fused_1(fused_1), .fused_2(fused_2), .fused_3(fused_3),
        .fused_4(fused_4), .fused_5(fused_5), .fused_6(fused_6), .fused_7(fused_7),
        .total_conflict_fault(total_conflict_fault)
    );

    // predictor state
    logic [15:0]     acc_mass [8];
    logic            acc_fault;
    emf_pkg::mode_t  cur_mode;
    fused_result_t   pending_results [$];
    int              errors;
    int              cycle_count;
    bit              rx_stall_en;
    bit              rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] sat_mass(logic [15:0] v);
        return (v > emf_pkg::QOne) ? emf_pkg::QOne : v;
    endfunction

    function automatic logic [15:0] round_sum(logic [63:0] s);
        logic [63:0] r;
        r = (s + 64'd16384) >> 15;
        return (r > 64'd32768) ? emf_pkg::QOne : r[15:0];
    endfunction

    function automatic void fuse_item(agent_item_t it);
        logic [15:0] m [8];
        logic [63:0] sums [8];
        logic [63:0] denom;
        logic [63:0] q;
        int idx;
        for (int i = 0; i < 8; i++)
        begin
            m[i] = sat_mass(it.mass[i]);
        end
        if (it.opcode == emf_pkg::OP_LOAD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                acc_mass[i] = m[i];
            end
            acc_fault = 1'b0;
        end
        else if (cur_mode != emf_pkg::MODE_HOLD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                sums[i] = 64'd0;
            end
            if (cur_mode == emf_pkg::MODE_DEMPSTER)
            begin
                acc_mass[0] = 16'd0;
            end
            for (int b = 0; b < 8; b++)
            begin
                for (int c = 0; c < 8; c++)
                begin
                    idx = (cur_mode == emf_pkg::MODE_DISJUNCTIVE) ? (b | c) : (b & c);
                    sums[idx] += 64'(acc_mass[b]) * 64'(m[c]);
                end
            end
            if (cur_mode != emf_pkg::MODE_DEMPSTER)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    acc_mass[i] = round_sum(sums[i]);
                end
            end
            else
            begin
                if (sums[0] >= (64'd1 << 30))
                begin
                    for (int i = 1; i < 8; i++)
                    begin
                        acc_mass[i] = 16'd0;
                    end
                    acc_fault = 1'b1;
                end
                else
                begin
                    denom = (64'd1 << 30) - sums[0];
                    for (int i = 1; i < 8; i++)
                    begin
                        q = ((sums[i] << 15) + (denom >> 1)) / denom;
                        acc_mass[i] = (q > 64'd32768) ? emf_pkg::QOne : q[15:0];
                    end
                end
                acc_mass[0] = round_sum(sums[0]);
            end
        end
    endfunction

    function automatic void predict_fusion(agent_item_t it);
        fused_result_t r;
        fuse_item(it);
        if (it.last_agent)
        begin
            for (int i = 0; i < 8; i++)
            begin
                r.fused[i] = acc_mass[i];
            end
            r.fault = acc_fault;
            pending_results.push_back(r);
        end
    endfunction

    function automatic logic [15:0] rand_mass();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return 16'd0;
        end
        else if (sel == 1)
        begin
            return emf_pkg::QOne;
        end
        else if (sel == 2)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 8192));
    endfunction

    // random agent masses, most of them normalized roughly to one
    function automatic agent_item_t rand_agent(logic op, logic last);
        agent_item_t it;
        int left;
        int v;
        it.opcode = op;
        it.last_agent = last;
        if ($urandom_range(0, 9) == 0)
        begin
            for (int i = 0; i < 8; i++)
            begin
                it.mass[i] = rand_mass();
            end
            return it;
        end
        left = 32768;
        for (int i = 0; i < 8; i++)
        begin
            it.mass[i] = 16'd0;
        end
        for (int i = 7; i >= 0; i--)
        begin
            v = (i == 0) ? left : $urandom_range(0, left);
            if ($urandom_range(0, 2) == 0)
            begin
                v = 0;
            end
            it.mass[i] = 16'(v);
            left -= v;
        end
        if ($urandom_range(0, 3) != 0)
        begin
            // in most items, fold the empty set mass into the full frame
            it.mass[7] = 16'(it.mass[7] + it.mass[0]);
            it.mass[0] = 16'd0;
        end
        return it;
    endfunction

    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 9);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_item(agent_item_t it, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            idle_burst();
        end
        in_valid   <= 1'b1;
        opcode     <= it.opcode;
        mass_0     <= it.mass[0];
        mass_1     <= it.mass[1];
        mass_2     <= it.mass[2];
        mass_3     <= it.mass[3];
        mass_4     <= it.mass[4];
        mass_5     <= it.mass[5];
        mass_6     <= it.mass[6];
        mass_7     <= it.mass[7];
        last_agent <= it.last_agent;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_fusion(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_mode(emf_pkg::mode_t m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode = m;
    endtask

    task automatic send_cell(int agents, bit gaps);
        send_item(rand_agent(emf_pkg::OP_LOAD, ($urandom_range(0, 5) == 0)), gaps);
        for (int a = 0; a < agents; a++)
        begin
            send_item(rand_agent(emf_pkg::OP_COMBINE, (a == agents - 1)), gaps);
        end
    endtask

    function automatic table_row_t mk_row(logic op, mass_vec_t m, logic last, logic has,
                                          mass_vec_t em, logic ef);
        table_row_t r;
        r.opcode = op;
        r.mass = m;
        r.last_agent = last;
        r.has_exp = has;
        r.exp_fused = em;
        r.exp_fault = ef;
        return r;
    endfunction

    // receiver with random stalls
    always @(negedge clk)
    begin
        if (rx_hold)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_stall_en && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        fused_result_t e;
        logic [15:0] got [8];
        if (rst_n && out_valid && out_ready)
        begin
            got = '{fused_0, fused_1, fused_2, fused_3, fused_4, fused_5, fused_6, fused_7};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item", $time);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                for (int i = 0; i < 8; i++)
                begin
                    if (got[i] !== e.fused[i])
                    begin
                        $display("%0t: fused_%0d expected %0d actual %0d",
                                 $time, i, e.fused[i], got[i]);
                        errors++;
                    end
                end
                if (total_conflict_fault !== e.fault)
                begin
                    $display("%0t: fault expected %0b actual %0b",
                             $time, e.fault, total_conflict_fault);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        table_row_t dir_rows [$];
        mass_vec_t z;
        mass_vec_t ones;
        mass_vec_t big;
        mass_vec_t vac;
        mass_vec_t conf_a;
        mass_vec_t conf_b;
        agent_item_t it;
        emf_pkg::mode_t ph_mode;
        int cells;
        errors = 0;
        cycle_count = 0;
        rx_stall_en = 1'b0;
        rx_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = emf_pkg::MODE_CONJUNCTIVE;
        in_valid = 1'b0;
        opcode = emf_pkg::OP_LOAD;
        {mass_0, mass_1, mass_2, mass_3, mass_4, mass_5, mass_6, mass_7} = '0;
        last_agent = 1'b0;
        out_ready = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            acc_mass[i] = 16'd0;
        end
        acc_fault = 1'b0;
        cur_mode = emf_pkg::MODE_CONJUNCTIVE;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        z      = '{default: 16'd0};
        ones   = '{default: emf_pkg::QOne};
        big    = '{16'hFFFF, 16'h8001, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        vac    = '{0, 0, 0, 0, 0, 0, 0, emf_pkg::QOne};
        conf_a = '{0, emf_pkg::QOne, 0, 0, 0, 0, 0, 0};
        conf_b = '{0, 0, emf_pkg::QOne, 0, 0, 0, 0, 0};

        // directed table in conjunctive mode (reset value)
        dir_rows.push_back(mk_row(emf_pkg::OP_COMBINE, vac, 1'b1, 1'b1, z, 1'b0));
        dir_rows.push_back(mk_row(emf_pkg::OP_LOAD, big, 1'b1, 1'b1,
            '{emf_pkg::QOne, emf_pkg::QOne, emf_pkg::QOne, 16'h7FFF,
              emf_pkg::QOne, emf_pkg::QOne, emf_pkg::QOne, emf_pkg::QOne}, 1'b0));
        dir_rows.push_back(mk_row(emf_pkg::OP_LOAD, ones, 1'b1, 1'b1, ones, 1'b0));
        dir_rows.push_back(mk_row(emf_pkg::OP_LOAD, vac, 1'b0, 1'b0, z, 1'b0));
        dir_rows.push_back(mk_row(emf_pkg::OP_COMBINE, conf_a, 1'b1, 1'b1, conf_a, 1'b0));
        dir_rows.push_back(mk_row(emf_pkg::OP_COMBINE, conf_b, 1'b1, 1'b1,
            '{emf_pkg::QOne, 0, 0, 0, 0, 0, 0, 0}, 1'b0));
        dir_rows.push_back(mk_row(emf_pkg::OP_LOAD, z, 1'b1, 1'b1, z, 1'b0));
        for (int k = 0; k < 4; k++)
        begin
            it = rand_agent(emf_pkg::OP_COMBINE, 1'b1);
            dir_rows.push_back(mk_row(k == 0 ? emf_pkg::OP_LOAD : emf_pkg::OP_COMBINE,
                                      it.mass, 1'b1, 1'b0, z, 1'b0));
        end
        foreach (dir_rows[i])
        begin
            it.opcode = dir_rows[i].opcode;
            it.mass = dir_rows[i].mass;
            it.last_agent = dir_rows[i].last_agent;
            send_item(it, 1'b0);
            if (dir_rows[i].has_exp && pending_results.size() != 0)
            begin
                if (pending_results[$].fused != dir_rows[i].exp_fused
                    || pending_results[$].fault != dir_rows[i].exp_fault)
                begin
                    $display("%0t: table row %0d predictor mismatch", $time, i);
                    errors++;
                end
            end
        end
        wait_drained();

        // dempster: total conflict, then a normal pair
        write_mode(emf_pkg::MODE_DEMPSTER);
        it.opcode = emf_pkg::OP_LOAD; it.mass = conf_a; it.last_agent = 1'b0;
        send_item(it, 1'b0);
        it.opcode = emf_pkg::OP_COMBINE; it.mass = conf_b; it.last_agent = 1'b1;
        send_item(it, 1'b0);
        it.mass = ones;
        send_item(it, 1'b0);
        it.opcode = emf_pkg::OP_LOAD; it.mass = vac; it.last_agent = 1'b1;
        send_item(it, 1'b0);
        send_cell(2, 1'b0);
        wait_drained();
        write_mode(emf_pkg::MODE_DISJUNCTIVE);
        send_cell(2, 1'b0);
        wait_drained();
        write_mode(emf_pkg::MODE_HOLD);
        send_cell(2, 1'b0);
        wait_drained();

        // random cells across modes
        rx_stall_en = 1'b1;
        cells = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            ph_mode = (ph == 7) ? emf_pkg::MODE_DEMPSTER
                                : emf_pkg::mode_t'($urandom_range(0, 3));
            write_mode(ph_mode);
            if (ph == 7)
            begin
                rx_stall_en = 1'b0;
            end
            if (ph == 2)
            begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (400) @(negedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            for (int c = 0; c < 37; c++)
            begin
                send_cell($urandom_range(1, 4), ph != 7);
                cells++;
            end
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/emf_pkg.sv
rtl/core/emf_ctrl.sv
rtl/core/emf_dp.sv
rtl/core/evidential_mass_fusion_top.sv
rtl/core/emf_checker.sv
tb/sv/tb_evidential_mass_fusion_top.sv
